// ===== src/point_decimate_voxel_dedup_assert.svh =====
// assertion macros for the point decimation block
`ifndef POINT_DECIMATE_VOXEL_DEDUP_ASSERT_SVH
`define POINT_DECIMATE_VOXEL_DEDUP_ASSERT_SVH
`ifndef ASSERT_OFF
`define PDV_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define PDV_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define PDV_ASSERT(label, clk, rst, prop)
`define PDV_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== src/pdvd_pkg.sv =====
// ----------------------------------------------------------------------------
// pdvd_pkg
// shared types, constants and register indexes for the point decimation block
// ----------------------------------------------------------------------------
package pdvd_pkg;

  localparam int TableDepthDef = 4096;
  localparam int MaxProbesDef  = 8;
  localparam int KeyBitsDef    = 20;
  localparam logic [7:0] DefaultIntensity = 8'd90;
  localparam logic [63:0] HashMult = 64'h9E3779B97F4A7C15;

  localparam logic [2:0] RegDecimation = 3'd0;
  localparam logic [2:0] RegVoxelScale = 3'd1;
  localparam logic [2:0] RegRotX       = 3'd2;
  localparam logic [2:0] RegRotY       = 3'd3;
  localparam logic [2:0] RegRotZ       = 3'd4;
  localparam logic [2:0] RegTransXy    = 3'd5;
  localparam logic [2:0] RegTransZ     = 3'd6;
  localparam logic [2:0] RegIntensity  = 3'd7;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MUL, ST_SUM, ST_KEY, ST_HASH, ST_HOME,
    ST_RD, ST_CMP, ST_OUT
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic mul;
    logic sum;
    logic key;
    logic hash;
    logic home;
    logic rd;
    logic cmp;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic go_table;
    logic probe_done;
  } stat_t;

endpackage

// ===== src/pdvd_ctrl.sv =====
// ----------------------------------------------------------------------------
// pdvd_ctrl
// sequencer: table clear, transform steps, probe loop, output hand-off
// ----------------------------------------------------------------------------
`include "point_decimate_voxel_dedup_assert.svh"
module pdvd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            out_busy,
  input  pdvd_pkg::stat_t stat,
  output pdvd_pkg::cmd_t  cmd,
  output logic            in_ready
);
  import pdvd_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (stat.clr_done) state_next = ST_IDLE;
      ST_IDLE:  if (in_valid) state_next = ST_MUL;
      ST_MUL:   state_next = ST_SUM;
      ST_SUM:   state_next = ST_KEY;
      ST_KEY:   state_next = stat.go_table ? ST_HASH : ST_OUT;
      ST_HASH:  state_next = ST_HOME;
      ST_HOME:  state_next = ST_RD;
      ST_RD:    state_next = ST_CMP;
      ST_CMP:   state_next = stat.probe_done ? ST_OUT : ST_RD;
      ST_OUT:   if (!out_busy) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MUL:  cmd.mul = 1'b1;
      ST_SUM:  cmd.sum = 1'b1;
      ST_KEY:  cmd.key = 1'b1;
      ST_HASH: cmd.hash = 1'b1;
      ST_HOME: cmd.home = 1'b1;
      ST_RD:   cmd.rd = 1'b1;
      ST_CMP:  cmd.cmp = 1'b1;
      ST_OUT:  cmd.emit = !out_busy;
      default: cmd = '0;
    endcase
  end

  `PDV_ASSERT(a_ready_idle, clk, rst, in_ready |-> state == ST_IDLE)
  `PDV_ASSERT(a_load_next, clk, rst, cmd.load |=> state == ST_MUL)
  `PDV_ASSERT(a_cmp_from_rd, clk, rst, state == ST_CMP |-> $past(state) == ST_RD)
endmodule

// ===== src/pdvd_datapath.sv =====
// ----------------------------------------------------------------------------
// pdvd_datapath
// config registers, transform, voxel key, hash, probe memory, output register
// ----------------------------------------------------------------------------
`include "point_decimate_voxel_dedup_assert.svh"
module pdvd_datapath #(
  parameter int TABLE_DEPTH = pdvd_pkg::TableDepthDef,
  parameter int MAX_PROBES  = pdvd_pkg::MaxProbesDef,
  parameter int KEY_BITS    = pdvd_pkg::KeyBitsDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic               coords_finite,
  input  pdvd_pkg::cmd_t     cmd,
  output pdvd_pkg::stat_t    stat,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               kept,
  output logic signed [31:0] world_x,
  output logic signed [31:0] world_y,
  output logic signed [31:0] world_z,
  output logic [7:0]         intensity,
  output logic [31:0]        sampled_total,
  output logic [31:0]        duplicates_total,
  output logic               table_overflow
);
  import pdvd_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int PW = $clog2(MAX_PROBES + 1);
  localparam int KW = 3 * KEY_BITS;

  // configuration
  logic [15:0] dec_step, vscale;
  logic [47:0] rot [3];
  logic signed [31:0] trans [3];
  logic [7:0] disp_int;

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_step <= 16'd1;
      vscale   <= '0;
      rot[0]   <= 48'h4000_0000_0000;
      rot[1]   <= 48'h0000_4000_0000;
      rot[2]   <= 48'h0000_0000_4000;
      trans[0] <= '0;
      trans[1] <= '0;
      trans[2] <= '0;
      disp_int <= DefaultIntensity;
    end else if (cfg_we) begin
      case (cfg_index)
        RegDecimation: dec_step <= cfg_data[15:0];
        RegVoxelScale: vscale   <= cfg_data[15:0];
        RegRotX:       rot[0]   <= cfg_data[47:0];
        RegRotY:       rot[1]   <= cfg_data[47:0];
        RegRotZ:       rot[2]   <= cfg_data[47:0];
        RegTransXy: begin
          trans[0] <= cfg_data[63:32];
          trans[1] <= cfg_data[31:0];
        end
        RegTransZ:     trans[2] <= cfg_data[31:0];
        RegIntensity:  disp_int <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // sampling and counters
  logic [15:0] phase;
  logic [31:0] samp_cnt, dup_cnt;
  logic        sampled, finite;
  logic signed [31:0] p [3];
  logic [15:0] step_eff;
  logic [16:0] phase_inc;

  assign step_eff  = (dec_step == '0) ? 16'd1 : dec_step;
  assign phase_inc = {1'b0, phase} + 17'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= '0;
      samp_cnt <= '0;
      sampled  <= 1'b0;
      finite   <= 1'b0;
    end else if (cmd.load) begin
      phase   <= (phase_inc >= {1'b0, step_eff}) ? '0 : phase_inc[15:0];
      sampled <= (phase == '0);
      finite  <= coords_finite;
      if (phase == '0 && samp_cnt != '1) samp_cnt <= samp_cnt + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p[0] <= point_x;
      p[1] <= point_y;
      p[2] <= point_z;
    end
  end

  // nine products, one 16x32 each, registered
  logic signed [47:0] prod [3][3];
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= $signed(rot[r][47 - 16*c -: 16]) * p[c];
        end
      end
    end
  end

  // sum, round, translate, saturate
  logic signed [31:0] w [3];
  logic signed [50:0] acc [3];
  logic signed [36:0] shf [3];
  logic signed [37:0] tsum [3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r]  = 51'(prod[r][0]) + 51'(prod[r][1]) + 51'(prod[r][2]) + 51'sd8192;
      shf[r]  = 37'(acc[r] >>> 14);
      tsum[r] = 38'(shf[r]) + 38'(trans[r]);
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      for (int r = 0; r < 3; r++) begin
        if (tsum[r] > 38'sh7FFFFFFF)       w[r] <= 32'sh7FFFFFFF;
        else if (tsum[r] < -38'sh80000000) w[r] <= 32'sh80000000;
        else                               w[r] <= tsum[r][31:0];
      end
    end
  end

  // voxel key: one 32x17 product per axis, floored and clamped
  logic [KW-1:0] key;
  logic signed [48:0] vprod [3];
  logic signed [24:0] kfl [3];
  logic [KEY_BITS-1:0] kfield [3];
  localparam logic signed [24:0] Half = 25'sd1 <<< (KEY_BITS - 1);
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      vprod[r] = 49'(w[r]) * $signed({1'b0, vscale});
      kfl[r]   = 25'(vprod[r] >>> 24);
      if (kfl[r] >= Half)       kfield[r] = '1;
      else if (kfl[r] < -Half)  kfield[r] = '0;
      else kfield[r] = KEY_BITS'(kfl[r] + Half);
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.key) key <= {kfield[0], kfield[1], kfield[2]};
  end
  assign stat.go_table = sampled && finite && (vscale != '0);

  // hash: bits 32 and up of key * mult, from three 32-bit partial products
  logic [63:0] kx;
  logic [31:0] hp_lo, hp_hi;
  assign kx = 64'(key);
  always_ff @(posedge clk) begin
    if (cmd.hash) begin
      hp_lo <= 32'(64'(kx[31:0]) * 64'(HashMult[63:32]))
             + 32'((64'(kx[31:0]) * 64'(HashMult[31:0])) >> 32);
      hp_hi <= 32'(64'(kx[63:32]) * 64'(HashMult[31:0]));
    end
  end
  logic [AW-1:0] slot;
  logic [PW-1:0] probes;
  logic          found_dup, found_free;

  // probe memory, valid bit on top of each entry, swept to zero after reset
  logic [KW:0]   keymem [TABLE_DEPTH];
  logic [KW:0]   rd_word;
  logic [KW-1:0] rd_key;
  logic          rd_v;
  logic [AW-1:0] clr_addr;
  logic          clr_done_r;
  assign stat.clr_done = clr_done_r;
  assign rd_v   = rd_word[KW];
  assign rd_key = rd_word[KW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.clr_step) keymem[clr_addr] <= '0;
    else if (cmd.cmp && !rd_v) keymem[slot] <= {1'b1, key};
    if (cmd.rd) rd_word <= keymem[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      clr_done_r <= 1'b0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(TABLE_DEPTH - 1)) clr_done_r <= 1'b1;
    end
  end

  logic [31:0] hsum;
  assign hsum = hp_lo + hp_hi;
  always_ff @(posedge clk) begin
    if (rst) begin
      dup_cnt    <= '0;
      found_dup  <= 1'b0;
      found_free <= 1'b0;
      probes     <= '0;
      slot       <= '0;
    end else begin
      if (cmd.load) begin
        found_dup  <= 1'b0;
        found_free <= 1'b0;
      end
      if (cmd.home) begin
        slot   <= hsum[AW-1:0];
        probes <= '0;
      end
      if (cmd.cmp) begin
        probes <= probes + PW'(1);
        slot   <= slot + AW'(1);
        if (!rd_v) begin
          found_free <= 1'b1;
        end else if (rd_key == key) begin
          found_dup <= 1'b1;
          if (dup_cnt != '1) dup_cnt <= dup_cnt + 32'd1;
        end
      end
    end
  end
  assign stat.probe_done = (!rd_v) || (rd_key == key) || (probes == PW'(MAX_PROBES - 1));

  // output register
  logic keep_w;
  logic over_w;
  assign keep_w = sampled && finite && !found_dup;
  assign over_w = stat.go_table && !found_dup && !found_free;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kept             <= keep_w;
      world_x          <= keep_w ? w[0] : '0;
      world_y          <= keep_w ? w[1] : '0;
      world_z          <= keep_w ? w[2] : '0;
      intensity        <= keep_w ? disp_int : '0;
      sampled_total    <= samp_cnt;
      duplicates_total <= dup_cnt;
      table_overflow   <= over_w;
    end
  end

  `PDV_ASSERT(a_dup_needs_table, clk, rst, (cmd.emit && found_dup) |-> stat.go_table)
  `PDV_ASSERT(a_not_both, clk, rst, !(found_dup && found_free))
  `PDV_ASSERT(a_emit_free, clk, rst, cmd.emit |-> (!out_valid || out_ready))
  `PDV_ASSERT_ALWAYS(a_reset_clears_out, clk, rst |=> !out_valid)
endmodule

// ===== src/point_decimate_voxel_dedup.sv =====
// ----------------------------------------------------------------------------
// point_decimate_voxel_dedup
// decimate, rigid transform and voxel dedup of a point stream
// ----------------------------------------------------------------------------
// steps: multiply, sum, key; an item that uses the table adds hash, home and
//   one read of the key memory and one compare per probe (1 to 8 probes)
// a new word is taken only after the last one has gone to the result register;
//   the hand-off waits while the result register holds a word not yet taken
// reset: synchronous; a sweep clears the table, input ready once the sweep is done
module point_decimate_voxel_dedup #(
  parameter int TABLE_DEPTH = pdvd_pkg::TableDepthDef,
  parameter int MAX_PROBES  = pdvd_pkg::MaxProbesDef,
  parameter int KEY_BITS    = pdvd_pkg::KeyBitsDef
) (
  input  logic               clk,
  input  logic               rst,
  // config write port
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  // input word
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic               coords_finite,
  // result word
  output logic               out_valid,
  input  logic               out_ready,
  output logic               kept,
  output logic signed [31:0] world_x,
  output logic signed [31:0] world_y,
  output logic signed [31:0] world_z,
  output logic [7:0]         intensity,
  output logic [31:0]        sampled_total,
  output logic [31:0]        duplicates_total,
  output logic               table_overflow
);
  import pdvd_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  // result register is busy while its word waits
  logic  out_busy;
  assign out_busy = out_valid && !out_ready;

  pdvd_ctrl u_ctrl (
    .clk, .rst, .in_valid, .out_busy, .stat, .cmd, .in_ready
  );

  pdvd_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH), .MAX_PROBES(MAX_PROBES), .KEY_BITS(KEY_BITS)
  ) u_dp (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .point_x, .point_y, .point_z, .coords_finite,
    .cmd, .stat, .out_ready, .out_valid, .kept,
    .world_x, .world_y, .world_z, .intensity,
    .sampled_total, .duplicates_total, .table_overflow
  );
endmodule

// ===== verif/point_decimate_voxel_dedup_tb.sv =====
// ----------------------------------------------------------------------------
// point_decimate_voxel_dedup_tb
// checks decimation, pose transform and voxel dedup against a local predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// expected result of one point word
typedef struct packed {
  logic        kept;
  logic [31:0] wx;
  logic [31:0] wy;
  logic [31:0] wz;
  logic [7:0]  inten;
  logic [31:0] sampled;
  logic [31:0] dups;
  logic        ovf;
} voxel_result_t;

class voxel_dedup_scoreboard;
  // register copy
  bit [15:0] step_reg;
  bit [15:0] scale_reg;
  bit [47:0] rot_x, rot_y, rot_z;
  bit [63:0] trans_xy;
  bit [31:0] trans_z;
  bit [7:0]  inten_reg;
  // predictor state
  int unsigned phase;
  bit [31:0] sampled_cnt, dup_cnt;
  bit [59:0] slot_key [4096];
  bit        slot_used [4096];
  voxel_result_t expected_q [$];
  int fails;

  function new();
    step_reg = 16'd1; scale_reg = 16'd0;
    rot_x = 48'h4000_0000_0000; rot_y = 48'h0000_4000_0000;
    rot_z = 48'h0000_0000_4000;
    trans_xy = 64'd0; trans_z = 32'd0; inten_reg = pdvd_pkg::DefaultIntensity;
    phase = 0; sampled_cnt = 0; dup_cnt = 0; fails = 0;
    foreach (slot_used[i]) slot_used[i] = 1'b0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [63:0] data);
    case (idx)
      pdvd_pkg::RegDecimation: step_reg  = data[15:0];
      pdvd_pkg::RegVoxelScale: scale_reg = data[15:0];
      pdvd_pkg::RegRotX:       rot_x     = data[47:0];
      pdvd_pkg::RegRotY:       rot_y     = data[47:0];
      pdvd_pkg::RegRotZ:       rot_z     = data[47:0];
      pdvd_pkg::RegTransXy:    trans_xy  = data;
      pdvd_pkg::RegTransZ:     trans_z   = data[31:0];
      pdvd_pkg::RegIntensity:  inten_reg = data[7:0];
      default: ;
    endcase
  endfunction

  // rounded Q2.14 dot product plus offset, clamped to 32 bits
  function longint world_axis(bit [47:0] row, longint px, longint py, longint pz,
                              longint ofs);
    longint acc;
    acc = longint'($signed(row[47:32])) * px + longint'($signed(row[31:16])) * py
        + longint'($signed(row[15:0])) * pz;
    acc = ((acc + 64'sd8192) >>> 14) + ofs;
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return acc;
  endfunction

  function bit [19:0] key_field(longint w);
    longint k;
    k = (w * longint'(scale_reg)) >>> 24;
    if (k > 64'sd524287) k = 64'sd524287;
    if (k < -64'sd524288) k = -64'sd524288;
    return 20'(k + 64'sd524288);
  endfunction

  function void note_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz, logic fin);
    voxel_result_t r;
    int unsigned step_eff;
    bit sampled, done;
    longint wx, wy, wz;
    bit [59:0] key;
    bit [63:0] prod;
    bit [11:0] slot;
    r = '0;
    step_eff = (step_reg == 0) ? 1 : step_reg;
    sampled = (phase == 0);
    phase = (phase + 1 >= step_eff) ? 0 : phase + 1;
    if (sampled) begin
      if (sampled_cnt != '1) sampled_cnt++;
      if (fin) begin
        wx = world_axis(rot_x, $signed(px), $signed(py), $signed(pz),
                        $signed(trans_xy[63:32]));
        wy = world_axis(rot_y, $signed(px), $signed(py), $signed(pz),
                        $signed(trans_xy[31:0]));
        wz = world_axis(rot_z, $signed(px), $signed(py), $signed(pz),
                        $signed(trans_z));
        r.kept = 1'b1;
        if (scale_reg != 0) begin
          key = {key_field(wx), key_field(wy), key_field(wz)};
          prod = {4'b0, key} * pdvd_pkg::HashMult;
          slot = prod[43:32];
          done = 1'b0;
          for (int i = 0; i < 8 && !done; i++) begin
            if (!slot_used[slot]) begin
              slot_used[slot] = 1'b1;
              slot_key[slot] = key;
              done = 1'b1;
            end else if (slot_key[slot] == key) begin
              r.kept = 1'b0;
              if (dup_cnt != '1) dup_cnt++;
              done = 1'b1;
            end
            slot = slot + 12'd1;
          end
          r.ovf = !done;
        end
        if (r.kept) begin
          r.wx = 32'(wx); r.wy = 32'(wy); r.wz = 32'(wz); r.inten = inten_reg;
        end
      end
    end
    r.sampled = sampled_cnt;
    r.dups = dup_cnt;
    expected_q = {expected_q, r};
  endfunction

  function void check_result(voxel_result_t got);
    voxel_result_t exp_r;
    if (expected_q.size() == 0) begin
      fails++;
      if (fails <= 10) $display("unexpected result word %h", got);
      return;
    end
    exp_r = expected_q.pop_front();
    if (got.kept !== exp_r.kept || got.wx !== exp_r.wx || got.wy !== exp_r.wy ||
        got.wz !== exp_r.wz || got.inten !== exp_r.inten ||
        got.sampled !== exp_r.sampled ||
        got.dups !== exp_r.dups || got.ovf !== exp_r.ovf) begin
      fails++;
      if (fails <= 10)
        $display({"mismatch kept %b/%b x %h/%h y %h/%h z %h/%h int %0d/%0d",
                  " smp %0d/%0d dup %0d/%0d ovf %b/%b (exp/act)"},
                 exp_r.kept, got.kept, exp_r.wx, got.wx, exp_r.wy, got.wy,
                 exp_r.wz, got.wz, exp_r.inten, got.inten,
                 exp_r.sampled, got.sampled, exp_r.dups, got.dups,
                 exp_r.ovf, got.ovf);
    end
  endfunction
endclass

module point_decimate_voxel_dedup_tb;
  import pdvd_pkg::*;

  localparam int CycleLimit = 600000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = RegDecimation;
  logic [63:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
  logic coords_finite = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic kept, table_overflow;
  logic signed [31:0] world_x, world_y, world_z;
  logic [7:0] intensity;
  logic [31:0] sampled_total, duplicates_total;

  voxel_dedup_scoreboard sb = new();
  int unsigned cycles = 0;
  int hold_left = 0;      // receiver hold-off, counted down by the receiver
  bit idle_on = 1'b1;     // random gaps on both sides
  int span = 18;          // magnitude bits of clustered points

  point_decimate_voxel_dedup dut (.*);

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // accepted input word goes to the predictor
  always @(posedge clk)
    if (!rst && in_valid && in_ready)
      sb.note_point(point_x, point_y, point_z, coords_finite);

  // accepted result word is checked
  always @(posedge clk)
    if (!rst && out_valid && out_ready)
      sb.check_result({kept, world_x, world_y, world_z, intensity, sampled_total,
                       duplicates_total, table_overflow});

  // receiver: long hold-offs on request, otherwise random stalls
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= !(idle_on && $urandom_range(99) < 8);
      end
    end
  end

  // one register write, then a gap with the write enable low
  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // offer one word and hold it until taken
  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz, logic fin);
    if (idle_on && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    point_x <= px;
    point_y <= py;
    point_z <= pz;
    coords_finite <= fin;
    do @(posedge clk); while (!in_ready);
  endtask

  // sender pauses until every expected word is back, then past the table latency
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [31:0] near_value();
    logic [31:0] v;
    v = $urandom_range((1 << span) - 1);
    return $urandom_range(1) ? -v : v;
  endfunction

  function automatic logic [47:0] pick_row(int axis);
    case ($urandom_range(3))
      0: return 48'h4000 << (16 * (2 - axis));   // identity row
      1: return {16'h8000, 16'h8000, 16'h8000};
      2: return {16'h7fff, 16'h7fff, 16'h7fff};
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  task automatic random_config();
    int sel;
    sel = $urandom_range(5);
    write_reg(RegDecimation, sel == 0 ? 64'd0 : sel == 1 ? 64'd65535 :
              sel == 2 ? 64'($urandom_range(7, 2)) : 64'd1);
    sel = $urandom_range(5);
    write_reg(RegVoxelScale, sel == 0 ? 64'd0 : sel == 1 ? 64'd65535 :
              sel == 2 ? 64'd1 : sel == 3 ? 64'($urandom) : 64'd256);
    write_reg(RegRotX, pick_row(0));
    write_reg(RegRotY, pick_row(1));
    write_reg(RegRotZ, pick_row(2));
    write_reg(RegTransXy, $urandom_range(1) ? 64'd0 : {$urandom, $urandom});
    write_reg(RegTransZ, $urandom_range(1) ? 64'h8000_0000 : 64'($urandom));
    write_reg(RegIntensity, 64'($urandom_range(255)));
    span = $urandom_range(20, 14);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset pose, extremes and a dropped point
    send_point(32'd0, 32'd0, 32'd0, 1'b1);
    send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1);
    send_point(32'h80000000, 32'h80000000, 32'h80000000, 1'b1);
    send_point(32'h12345678, 32'h9abcdef0, 32'h0badcafe, 1'b0);
    drain();
    // extreme pose with saturation and dedup of the same voxel
    write_reg(RegRotX, {16'h7fff, 16'h7fff, 16'h7fff});
    write_reg(RegRotY, {16'h8000, 16'h8000, 16'h8000});
    write_reg(RegRotZ, {16'h8000, 16'h7fff, 16'h0001});
    write_reg(RegTransXy, 64'h7fffffff_80000000);
    write_reg(RegTransZ, 64'hffff_0000);
    write_reg(RegIntensity, 64'd255);
    write_reg(RegVoxelScale, 64'd256);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b1);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b1);
    send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b1);
    send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b1);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0);
    drain();
    // step of zero, then step lowered below the phase
    write_reg(RegDecimation, 64'd0);
    write_reg(RegIntensity, 64'd0);
    write_reg(RegVoxelScale, 64'd65535);
    send_point(32'h0000_1000, 32'h0, 32'h0, 1'b1);
    send_point(32'h0000_2000, 32'h0, 32'h0, 1'b1);
    drain();
    write_reg(RegDecimation, 64'd5);
    repeat (3) send_point(near_value(), near_value(), near_value(), 1'b1);
    drain();
    write_reg(RegDecimation, 64'd2);
    repeat (4) send_point(near_value(), near_value(), near_value(), 1'b1);
    drain();

    // random phases, each under its own settings
    for (int ph = 0; ph < 10; ph++) begin
      random_config();
      idle_on = (ph != 3);                    // one phase runs with no gaps
      if (ph == 5) hold_left = 300;           // long receiver hold-off
      for (int n = 0; n < 95; n++) begin
        if ($urandom_range(3) != 0)
          send_point(near_value(), near_value(), near_value(), $urandom_range(9) != 0);
        else
          send_point($urandom, $urandom, $urandom, $urandom_range(1));
      end
      drain();
    end

    if (sb.fails == 0 && sb.expected_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
